>>> rtl/ppm_pkg.sv
package ppm_pkg;

   // Width of one exponent word on the request side.
   localparam int EXP_W = 32;

   // Width of a residue modulo the prime.
   localparam int RES_W = 30;

   // Default number of exponent bits that take part in a power.
   localparam int EXP_BITS_DEFAULT = 32;

   // The prime modulus.
   localparam logic [RES_W-1:0] PRIME_MOD = 30'd998244353;

   // Base of the inner power.
   localparam logic [RES_W-1:0] INNER_BASE = 30'd2;

   // Neutral element of a product.
   localparam logic [RES_W-1:0] RES_ONE = 30'd1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DONE
   } ppm_state_type;

endpackage

>>> rtl/mod_prime_power_of_mersenne.sv
// Computes (2^k - 1)^n mod 998244353 for k = req_period_count and
// n = req_term_count, as two right-to-left square-and-multiply powers that
// share one bit-serial modular multiplier. The multiplier takes one operand
// bit per cycle, and only exponent bits up to the highest set one are
// processed. A new word is taken only when the block is idle again after
// the rsp_valid strobe, so the block works on one word at a time.
// busy stays high until the result has been shown.
// The result is valid on rsp_residue in the one cycle that rsp_valid
// is high; the receiver has to take it then, there is no stall.
module mod_prime_power_of_mersenne
   import ppm_pkg::*;
#(
   parameter int EXP_BITS = EXP_BITS_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [EXP_W-1:0]  req_term_count,
   input  logic [EXP_W-1:0]  req_period_count,
   output logic              rsp_valid,
   output logic [RES_W-1:0]  rsp_residue
);

   // Exponent bits above EXP_BITS are ignored.
   localparam logic [EXP_W-1:0] EXP_MASK = (EXP_BITS >= EXP_W) ? {EXP_W{1'b1}} :
      EXP_W'((64'd1 << EXP_BITS) - 64'd1);

   ppm_state_type     state_ff, state_in;
   logic              outer_ff, outer_in;
   logic [EXP_W-1:0]  exp_ff, exp_in;
   logic [EXP_W-1:0]  term_ff, term_in;
   logic [RES_W-1:0]  acc_ff, acc_in;
   logic [RES_W-1:0]  base_ff, base_in;
   logic              mul_start;
   logic              mul_done;
   logic [RES_W-1:0]  prod_acc;
   logic [RES_W-1:0]  prod_sq;
   logic              accept;

   assign accept = start && (state_ff == ST_IDLE);

   // Shared multiplier: acc * base and base * base in one pass.
   ppm_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .mcand_acc (acc_ff),
      .mcand_sq  (base_ff),
      .mplier    (base_ff),
      .done      (mul_done),
      .prod_acc  (prod_acc),
      .prod_sq   (prod_sq)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (exp_ff != '0) begin
               state_in = ST_MUL;
            end else if (outer_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      mul_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_CHECK: begin
            mul_start = (exp_ff != '0);
         end
         ST_MUL: begin
            busy = 1'b1;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Working registers of the two powers.
   always_comb begin
      outer_in = outer_ff;
      exp_in   = exp_ff;
      term_in  = term_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      if (accept) begin
         outer_in = 1'b0;
         exp_in   = req_period_count & EXP_MASK;
         term_in  = req_term_count & EXP_MASK;
         acc_in   = RES_ONE;
         base_in  = INNER_BASE;
      end else if (state_ff == ST_CHECK && exp_ff == '0 && !outer_ff) begin
         // 2^k mod p is never zero, so subtracting one cannot wrap.
         outer_in = 1'b1;
         exp_in   = term_ff;
         acc_in   = RES_ONE;
         base_in  = acc_ff - RES_ONE;
      end else if (state_ff == ST_MUL && mul_done) begin
         if (exp_ff[0]) begin
            acc_in = prod_acc;
         end
         base_in = prod_sq;
         exp_in  = {1'b0, exp_ff[EXP_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         outer_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         outer_ff <= outer_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff  <= exp_in;
      term_ff <= term_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
   end

   assign rsp_residue = acc_ff;

   // A delivered residue is always reduced.
   a_residue_reduced : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_residue < PRIME_MOD))
      else $error("residue not reduced modulo the prime");

   // Exactly one result per word: the strobe drops again right after it rises.
   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // An accepted word makes the block busy in the next cycle.
   a_busy_after_start : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a word");

   // The multiplier is never restarted while a product is pending.
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> !mul_start)
      else $error("multiplier started while busy");

endmodule

>>> rtl/ppm_mul.sv
// Dual bit-serial modular multiplier. Both products share the multiplier
// operand, so one shift register scans its bits from the top down while two
// partial products are doubled and conditionally added, one bit per cycle.
module ppm_mul
   import ppm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [RES_W-1:0]         mcand_acc,
   input  logic [RES_W-1:0]         mcand_sq,
   input  logic [RES_W-1:0]         mplier,
   output logic                     done,
   output logic [RES_W-1:0]         prod_acc,
   output logic [RES_W-1:0]         prod_sq
);

   localparam int CNT_W = $clog2(RES_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RES_W - 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [RES_W-1:0]     mplier_ff, mplier_in;
   logic [RES_W-1:0]     part_acc_ff, part_acc_in;
   logic [RES_W-1:0]     part_sq_ff, part_sq_in;

   // One step: part = (2 * part + bit * addend) mod p, both operands below p.
   function automatic logic [RES_W-1:0] dbl_add(input logic [RES_W-1:0] part,
                                                 input logic [RES_W-1:0] addend,
                                                 input logic use_add);
      logic [RES_W:0] dbl;
      logic [RES_W:0] sum;
      dbl = {part, 1'b0};
      if (dbl >= {1'b0, PRIME_MOD}) begin
         dbl = dbl - {1'b0, PRIME_MOD};
      end
      sum = dbl + (use_add ? {1'b0, addend} : '0);
      if (sum >= {1'b0, PRIME_MOD}) begin
         sum = sum - {1'b0, PRIME_MOD};
      end
      return sum[RES_W-1:0];
   endfunction

   // Load on start, then take one multiplier bit per cycle.
   always_comb begin
      run_in      = run_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      mplier_in   = mplier_ff;
      part_acc_in = part_acc_ff;
      part_sq_in  = part_sq_ff;
      if (start) begin
         run_in      = 1'b1;
         cnt_in      = CNT_LAST;
         mplier_in   = mplier;
         part_acc_in = '0;
         part_sq_in  = '0;
      end else if (run_ff) begin
         part_acc_in = dbl_add(part_acc_ff, mcand_acc, mplier_ff[RES_W-1]);
         part_sq_in  = dbl_add(part_sq_ff, mcand_sq, mplier_ff[RES_W-1]);
         mplier_in   = {mplier_ff[RES_W-2:0], 1'b0};
         cnt_in      = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mplier_ff   <= mplier_in;
      part_acc_ff <= part_acc_in;
      part_sq_ff  <= part_sq_in;
   end

   assign done     = done_ff;
   assign prod_acc = part_acc_ff;
   assign prod_sq  = part_sq_ff;

endmodule

>>> tb/mod_prime_power_of_mersenne_tb.sv
`timescale 1ns / 100ps

module mod_prime_power_of_mersenne_tb;
   import ppm_pkg::*;

   localparam int RANDOM_WORDS = 550;
   localparam logic [EXP_W-1:0] GROUP_ORDER = 32'd998244352;

   logic             clock;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [EXP_W-1:0] req_term_count = '0;
   logic [EXP_W-1:0] req_period_count = '0;
   logic             rsp_valid;
   logic [RES_W-1:0] rsp_residue;

   mod_prime_power_of_mersenne dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_term_count   (req_term_count),
      .req_period_count (req_period_count),
      .rsp_valid        (rsp_valid),
      .rsp_residue      (rsp_residue)
   );

   // One expected residue together with the word that produced it.
   typedef struct {
      logic [EXP_W-1:0] term_count;
      logic [EXP_W-1:0] period_count;
      logic [RES_W-1:0] residue;
   } pending_residue_type;

   // Predicts the residue of every accepted word and checks the strobed results in order.
   class residue_board;
      pending_residue_type awaited[$];
      int                  fail_count = 0;

      // Right-to-left square and multiply over all exponent bits.
      function automatic logic [RES_W-1:0] mod_pow(logic [RES_W-1:0] base,
                                                   logic [EXP_W-1:0] exponent);
         logic [63:0] product;
         logic [63:0] square;
         product = 64'd1;
         square = base % PRIME_MOD;
         for (int i = 0; i < EXP_W; i++) begin
            if (exponent[i]) begin
               product = (product * square) % PRIME_MOD;
            end
            square = (square * square) % PRIME_MOD;
         end
         return product[RES_W-1:0];
      endfunction

      // (2^k - 1)^n modulo the prime.
      function automatic logic [RES_W-1:0] mersenne_power(logic [EXP_W-1:0] term_count,
                                                          logic [EXP_W-1:0] period_count);
         logic [63:0] two_power;
         logic [63:0] base;
         two_power = mod_pow(INNER_BASE, period_count);
         base = (two_power + PRIME_MOD - 64'd1) % PRIME_MOD;
         return mod_pow(base[RES_W-1:0], term_count);
      endfunction

      task report_mismatch(string text);
         $display("[%0t] MISMATCH: %s", $time, text);
         fail_count++;
      endtask

      // Called for every word the block accepts.
      function void note_word(logic [EXP_W-1:0] term_count, logic [EXP_W-1:0] period_count);
         pending_residue_type entry;
         entry.term_count = term_count;
         entry.period_count = period_count;
         entry.residue = mersenne_power(term_count, period_count);
         awaited.push_back(entry);
      endfunction

      // Called for every strobed result.
      task check_residue(logic [RES_W-1:0] residue);
         pending_residue_type entry;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("unexpected result residue=%0d", residue));
         end else begin
            entry = awaited.pop_front();
            if (residue !== entry.residue) begin
               report_mismatch($sformatf("rsp_residue got %0d expected %0d (n=%0d k=%0d)",
                                         residue, entry.residue, entry.term_count,
                                         entry.period_count));
            end
         end
      endtask

      function int pending();
         return awaited.size();
      endfunction
   endclass

   residue_board board;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Results are only shown for one cycle, so every strobe is checked at its edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_residue(rsp_residue);
      end
   end

   // Presents one word and holds it until the block takes it.
   task send_word(logic [EXP_W-1:0] term_count, logic [EXP_W-1:0] period_count);
      req_term_count <= term_count;
      req_period_count <= period_count;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_word(term_count, period_count);
   endtask

   // Drops start for a while; only cycles where the block is free count as idle.
   task hold_off(int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while (busy || $urandom_range(99) < idle_pct);
      end
   endtask

   // A value of random width up to ten bits, which keeps most words short.
   function automatic logic [EXP_W-1:0] narrow_value();
      int bits = $urandom_range(0, 10);
      return $urandom & ((32'd1 << bits) - 32'd1);
   endfunction

   // Directed corners, then random words in several idling phases.
   initial begin
      logic [EXP_W-1:0] term_pick;
      logic [EXP_W-1:0] period_pick;
      int               kind;
      int               idle_pct;

      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero exponents, a zero base (k = 0 or a multiple of p - 1) and full-width values.
      send_word(32'd0, 32'd0);
      send_word(32'd1, 32'd0);
      send_word(32'hFFFF_FFFF, 32'd0);
      send_word(32'd0, 32'hFFFF_FFFF);
      send_word(32'd0, GROUP_ORDER);
      send_word(32'd5, GROUP_ORDER);
      send_word(32'hFFFF_FFFF, GROUP_ORDER);
      send_word(32'd1, GROUP_ORDER * 2);
      send_word(32'd7, GROUP_ORDER * 4);
      send_word(32'd3, GROUP_ORDER * 3);
      send_word(32'd1, 32'd1);
      send_word(32'd2, 32'd1);
      send_word(32'd1, 32'd30);
      send_word(32'd2, 32'd30);
      send_word(32'd3, 32'd31);
      send_word(32'd1, 32'd32);
      send_word(32'h8000_0000, 32'h8000_0000);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(32'hAAAA_AAAA, 32'h5555_5555);
      send_word(32'h5555_5555, 32'hAAAA_AAAA);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         // Phases: back to back, mostly idle, back to back again, lightly idle.
         case ((i * 4) / RANDOM_WORDS)
            0: begin
               idle_pct = 0;
            end
            1: begin
               idle_pct = 75;
            end
            2: begin
               idle_pct = 0;
            end
            default: begin
               idle_pct = 28;
            end
         endcase
         kind = $urandom_range(99);
         if (kind < 15) begin
            term_pick = $urandom;
            period_pick = $urandom;
         end else if (kind < 22) begin
            term_pick = narrow_value();
            period_pick = GROUP_ORDER * $urandom_range(1, 4);
         end else if (kind < 28) begin
            term_pick = $urandom;
            period_pick = narrow_value();
         end else begin
            term_pick = narrow_value();
            period_pick = narrow_value();
         end
         hold_off(idle_pct);
         send_word(term_pick, period_pick);
      end
      start <= 1'b0;

      // Drain what is still in flight.
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
